/* rtl/jdc_pkg.sv */
// ----------------------------------------------------------------------------
// jdc_pkg
// Shared widths, reciprocal constants and tables for the Julian date to
// calendar converter.
// ----------------------------------------------------------------------------
package jdc_pkg;

	localparam int JD_W     = 40;
	localparam int YEAR_W   = 16;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;

	localparam int NUM_STAGES = 14;

	localparam logic [15:0] HALF_DAY      = 16'd43200;
	localparam logic [9:0]  DAY_ODD       = 10'd675;
	localparam logic [23:0] GREG_START    = 24'd2299161;
	localparam logic [25:0] ALPHA_BIAS    = 26'd7468865;
	localparam logic [10:0] B_OFFSET      = 11'd1524;
	localparam logic [13:0] C_BIAS        = 14'd12210;
	localparam logic [10:0] DAYS_4Y       = 11'd1461;
	localparam logic [13:0] E_SCALE       = 14'd10000;
	localparam logic [5:0]  SIXTY         = 6'd60;
	localparam logic [12:0] YEAR_OFS_LATE = 13'd4716;
	localparam logic [12:0] YEAR_OFS_EARLY = 13'd4715;

	// Reciprocals for exact floor division: floor(x * M / 2^k) == floor(x / d).
	localparam logic [17:0] M_DAY_HI = 18'(((64'd1 << 27) + 64'd674) / 64'd675);
	localparam logic [27:0] M_DAY_LO = 28'(((64'd1 << 37) + 64'd674) / 64'd675);
	localparam logic [17:0] M_MIN    = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
	localparam logic [11:0] M_HOUR   = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
	localparam logic [26:0] M_ALPHA  = 27'(((64'd1 << 44) + 64'd146096) / 64'd146097);
	localparam logic [31:0] M_CENT   = 32'(((64'd1 << 47) + 64'd36524) / 64'd36525);
	localparam logic [23:0] M_MONTH  = 24'(((64'd1 << 42) + 64'd306000) / 64'd306001);

	// Whole days before month index e, that is floor(30.6001 * e).
	localparam logic [8:0] DAYS_BEFORE [0:15] = '{
		9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
		9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
	};

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} tod_t;

endpackage

/* rtl/jdc_if.sv */
// ----------------------------------------------------------------------------
// jdc_if
// Request channels of the Julian date to calendar converter.
// ----------------------------------------------------------------------------
interface jdc_stamp_if;
	import jdc_pkg::*;

	logic            valid;
	logic            ready;
	logic [JD_W-1:0] jd_seconds;

	modport source (output valid, output jd_seconds, input ready);
	modport sink (input valid, input jd_seconds, output ready);
endinterface

interface jdc_date_if;
	import jdc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [YEAR_W-1:0] year;
	logic [MONTH_W-1:0]       month;
	logic [DAY_W-1:0]         day;
	logic [HOUR_W-1:0]        hour;
	logic [MINUTE_W-1:0]      minute;
	logic [SECOND_W-1:0]      second;

	modport source (output valid, output year, output month, output day,
		output hour, output minute, output second, input ready);
	modport sink (input valid, input year, input month, input day,
		input hour, input minute, input second, output ready);
endinterface

/* rtl/julian_date_to_calendar.sv */
// ----------------------------------------------------------------------------
// julian_date_to_calendar
// Converts a Julian date in whole seconds into calendar date and time of day.
// ----------------------------------------------------------------------------
// Each request on stamp carries a Julian date times 86400. The block answers
// with one request on date holding the astronomical year, month, day, hour,
// minute and second. Dates before Julian day 2299161 use the Julian calendar,
// later ones the Gregorian calendar.
// The pipeline has 14 register stages. One request is taken every cycle
// unless date stalls with a result waiting; the rate is set by the pipeline,
// in which every constant division other than a power-of-two shift is a
// reciprocal multiplication followed by a register.
// Reset clears all valid bits; data registers are not reset.
// When the receiver holds date.ready low with a result waiting, the whole
// pipeline freezes and stamp.ready drops in the same cycle; nothing is lost
// or repeated. Bubbles in the pipeline are kept while it is frozen.
// ----------------------------------------------------------------------------
module julian_date_to_calendar (
	input  logic           clk,
	input  logic           arst_n,
	jdc_stamp_if.sink      stamp,
	jdc_date_if.source     date
);
	import jdc_pkg::*;

	logic                  adv;
	logic [NUM_STAGES:1]   vld_q;

	logic [40:0] t_s1;
	logic [7:0]  q1_s2;
	logic [16:0] xhi_s2, xlo_s2;
	logic [6:0]  tlo_s2;
	logic [26:0] y_s3;
	logic [7:0]  q1_s3;
	logic [6:0]  tlo_s3;
	logic [16:0] q2_s4;
	logic [26:0] y_s4;
	logic [7:0]  q1_s4;
	logic [6:0]  tlo_s4;
	logic [23:0] z_s5;
	logic [16:0] sod_s5;
	logic [25:0] num_s6;
	logic        greg_s6;
	logic [23:0] z_s6;
	logic [10:0] mt_s6;
	logic [16:0] sod_s6;
	logic [8:0]  alpha_s7;
	logic        greg_s7;
	logic [23:0] z_s7;
	logic [4:0]  hour_s7;
	logic [10:0] mt_s7;
	logic [5:0]  sec_s7;
	logic [24:0] b_s8, b_s9, b_s10;
	tod_t        tod_s8, tod_s9, tod_s10, tod_s11, tod_s12, tod_s13;
	logic [30:0] cn_s9;
	logic [15:0] c_s10, c_s11, c_s12, c_s13;
	logic [8:0]  bd_s11, bd_s12, bd_s13;
	logic [22:0] x_s12;
	logic [3:0]  e_s13;

	logic signed [YEAR_W-1:0] year_s14;
	logic [MONTH_W-1:0]       month_s14;
	logic [DAY_W-1:0]         day_s14;
	tod_t                     tod_s14;

	logic [34:0] prod1;
	logic [16:0] q1x;
	logic [9:0]  r1;
	logic [54:0] prod2;
	logic [26:0] q2x;
	logic [9:0]  r2;
	logic        greg_c;
	logic [34:0] prods;
	logic [52:0] proda;
	logic [22:0] prodh;
	logic [16:0] msec;
	logic [24:0] a_c;
	logic [10:0] mhour;
	logic [31:0] cn_c;
	logic [62:0] prodc;
	logic [25:0] d1461;
	logic [24:0] dd;
	logic [46:0] prode;
	logic [3:0]  mon_c;
	logic signed [16:0] yr_c;
	logic [8:0]  dom_c;

	assign adv        = !vld_q[NUM_STAGES] || date.ready;
	assign stamp.ready = adv;
	assign date.valid  = vld_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NUM_STAGES-1:1], stamp.valid};
		end
	end

	always_comb begin
		prod1 = 35'(t_s1[40:24]) * 35'(M_DAY_HI);
		q1x   = 17'(q1_s2) * 17'(DAY_ODD);
		r1    = 10'(xhi_s2 - q1x);
		prod2 = 55'(y_s3) * 55'(M_DAY_LO);
		q2x   = 27'(q2_s4) * 27'(DAY_ODD);
		r2    = 10'(y_s4 - q2x);
		greg_c = (z_s5 >= GREG_START);
		prods = 35'(sod_s5) * 35'(M_MIN);
		proda = 53'(num_s6) * 53'(M_ALPHA);
		prodh = 23'(mt_s6) * 23'(M_HOUR);
		msec  = 17'(mt_s6) * 17'(SIXTY);
		if (greg_s7) begin
			a_c = 25'(z_s7) + 25'd1 + 25'(alpha_s7) - 25'(alpha_s7 >> 2);
		end else begin
			a_c = 25'(z_s7);
		end
		mhour = 11'(hour_s7) * 11'(SIXTY);
		cn_c  = 32'(b_s8) * 32'd100 - 32'(C_BIAS);
		prodc = 63'(cn_s9) * 63'(M_CENT);
		d1461 = 26'(c_s10) * 26'(DAYS_4Y);
		dd    = 25'(d1461[25:2]);
		prode = 47'(x_s12) * 47'(M_MONTH);
		if (e_s13 <= 4'd13) begin
			mon_c = e_s13 - 4'd1;
		end else begin
			mon_c = e_s13 - 4'd13;
		end
		if (mon_c > 4'd2) begin
			yr_c = $signed({1'b0, c_s13}) - $signed({4'b0000, YEAR_OFS_LATE});
		end else begin
			yr_c = $signed({1'b0, c_s13}) - $signed({4'b0000, YEAR_OFS_EARLY});
		end
		dom_c = bd_s13 - DAYS_BEFORE[e_s13];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Split the shifted seconds count into day number and second of day.
			t_s1 <= 41'(stamp.jd_seconds) + 41'(HALF_DAY);

			q1_s2  <= prod1[34:27];
			xhi_s2 <= t_s1[40:24];
			xlo_s2 <= t_s1[23:7];
			tlo_s2 <= t_s1[6:0];

			y_s3   <= {r1, xlo_s2};
			q1_s3  <= q1_s2;
			tlo_s3 <= tlo_s2;

			q2_s4  <= prod2[53:37];
			y_s4   <= y_s3;
			q1_s4  <= q1_s3;
			tlo_s4 <= tlo_s3;

			z_s5   <= 24'({q1_s4, q2_s4});
			sod_s5 <= {r2, tlo_s4};

			num_s6  <= greg_c ? ({z_s5, 2'b00} - ALPHA_BIAS) : '0;
			greg_s6 <= greg_c;
			z_s6    <= z_s5;
			mt_s6   <= prods[33:23];
			sod_s6  <= sod_s5;

			alpha_s7 <= proda[52:44];
			greg_s7  <= greg_s6;
			z_s7     <= z_s6;
			hour_s7  <= prodh[21:17];
			mt_s7    <= mt_s6;
			sec_s7   <= 6'(sod_s6 - msec);

			b_s8          <= a_c + 25'(B_OFFSET);
			tod_s8.hour   <= hour_s7;
			tod_s8.minute <= 6'(mt_s7 - mhour);
			tod_s8.second <= sec_s7;

			cn_s9  <= cn_c[30:0];
			b_s9   <= b_s8;
			tod_s9 <= tod_s8;

			c_s10   <= prodc[62:47];
			b_s10   <= b_s9;
			tod_s10 <= tod_s9;

			c_s11   <= c_s10;
			bd_s11  <= 9'(b_s10 - dd);
			tod_s11 <= tod_s10;

			x_s12   <= 23'(bd_s11) * 23'(E_SCALE);
			bd_s12  <= bd_s11;
			c_s12   <= c_s11;
			tod_s12 <= tod_s11;

			e_s13   <= prode[45:42];
			bd_s13  <= bd_s12;
			c_s13   <= c_s12;
			tod_s13 <= tod_s12;

			year_s14  <= yr_c[15:0];
			month_s14 <= mon_c;
			day_s14   <= dom_c[4:0];
			tod_s14   <= tod_s13;
		end
	end

	assign date.year   = year_s14;
	assign date.month  = month_s14;
	assign date.day    = day_s14;
	assign date.hour   = tod_s14.hour;
	assign date.minute = tod_s14.minute;
	assign date.second = tod_s14.second;

	a_bd_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[11] |-> (bd_s11 >= 9'd122) && (bd_s11 <= 9'd488))
		else $error("Day remainder out of range after the century step.");

	a_e_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[13] |-> (e_s13 >= 4'd3) && (e_s13 <= 4'd15))
		else $error("Month index out of range.");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		date.valid |-> (date.month >= 4'd1) && (date.month <= 4'd12) &&
			(date.day >= 5'd1))
		else $error("Calendar date out of range.");

	a_tod_range: assert property (@(posedge clk) disable iff (!arst_n)
		date.valid |-> (date.hour <= 5'd23) && (date.minute <= 6'd59) &&
			(date.second <= 6'd59))
		else $error("Time of day out of range.");

	a_sod_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[5] |-> (sod_s5 < 17'd86400))
		else $error("Second of day out of range.");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the Julian date to calendar converter.
// ----------------------------------------------------------------------------
// A table of directed timestamps comes first: the ends of the input range,
// midnight and the last second of a day, the switch from the Julian to the
// Gregorian calendar and a leap day. Random timestamps follow, half spread
// over the whole range and the rest near the calendar switch, day boundaries
// and modern dates. Untabled requests are converted by an integer model
// of the date arithmetic in the testbench, and results are compared in
// order. The sender works in bursts with gaps, and the receiver stalls on
// patterns of its own, including one long hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
	import jdc_pkg::*;

	typedef struct packed {
		logic signed [YEAR_W-1:0] year;
		logic [MONTH_W-1:0]       month;
		logic [DAY_W-1:0]         day;
		logic [HOUR_W-1:0]        hour;
		logic [MINUTE_W-1:0]      minute;
		logic [SECOND_W-1:0]      second;
	} cal_t;

	typedef struct packed {
		logic [JD_W-1:0] jd;
		logic            typed;
		cal_t            cal;
	} stamp_row_t;

	typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

	localparam int RANDOM_ITEMS = 1400;
	localparam int HOLD_CYCLES  = 80;
	localparam int NUM_ROWS     = 17;

	localparam stamp_row_t STAMP_ROWS [NUM_ROWS] = '{
		'{40'd0,             1'b1, '{-16'sd4712, 4'd1,  5'd1,  5'd12, 6'd0,  6'd0}},
		'{40'd1,             1'b1, '{-16'sd4712, 4'd1,  5'd1,  5'd12, 6'd0,  6'd1}},
		'{40'd43199,         1'b1, '{-16'sd4712, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59}},
		'{40'd43200,         1'b1, '{-16'sd4712, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0}},
		'{40'd198647380800,  1'b1, '{16'sd1582,  4'd10, 5'd4,  5'd0,  6'd0,  6'd0}},
		'{40'd198647467199,  1'b1, '{16'sd1582,  4'd10, 5'd4,  5'd23, 6'd59, 6'd59}},
		'{40'd198647467200,  1'b1, '{16'sd1582,  4'd10, 5'd15, 5'd0,  6'd0,  6'd0}},
		'{40'd211813488000,  1'b1, '{16'sd2000,  4'd1,  5'd1,  5'd12, 6'd0,  6'd0}},
		'{40'd211813358400,  1'b0, '0},
		'{40'd211818542400,  1'b0, '0},
		'{40'd211818628800,  1'b0, '0},
		'{40'd1099511627775, 1'b0, '0},
		'{40'd1099511627774, 1'b0, '0},
		'{40'h5555555555,    1'b0, '0},
		'{40'hAAAAAAAAAA,    1'b0, '0},
		'{40'h8000000000,    1'b0, '0},
		'{40'h7FFFFFFFFF,    1'b0, '0}
	};

	localparam int unsigned DAY_BOUNDARY_SODS [6] = '{0, 1, 43199, 43200, 86398, 86399};

	logic clk;
	logic arst_n;

	jdc_stamp_if stamp ();
	jdc_date_if  date ();

	julian_date_to_calendar u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stamp  (stamp),
		.date   (date)
	);

	cal_t pending_dates [$];
	int   mismatches = 0;
	bit   hold_req   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb NOT OK");
		$finish;
	end

	function automatic cal_t jd_to_calendar(input logic [JD_W-1:0] jd);
		longint unsigned t, z, sod, alpha, a, b, c, d, e, dom, mon;
		longint          yr;
		cal_t            r;
		t   = 64'(jd) + 64'd43200;
		z   = t / 64'd86400;
		sod = t % 64'd86400;
		if (z < 64'd2299161) begin
			a = z;
		end else begin
			alpha = (64'd4 * z - 64'd7468865) / 64'd146097;
			a     = z + 64'd1 + alpha - alpha / 64'd4;
		end
		b   = a + 64'd1524;
		c   = (64'd100 * b - 64'd12210) / 64'd36525;
		d   = (64'd1461 * c) / 64'd4;
		e   = (64'd10000 * (b - d)) / 64'd306001;
		dom = b - d - (64'd306001 * e) / 64'd10000;
		mon = (e <= 64'd13) ? e - 64'd1 : e - 64'd13;
		yr  = (mon > 64'd2) ? longint'(c) - 64'sd4716 : longint'(c) - 64'sd4715;
		r.year   = yr[YEAR_W-1:0];
		r.month  = mon[MONTH_W-1:0];
		r.day    = dom[DAY_W-1:0];
		r.hour   = HOUR_W'(sod / 64'd3600);
		r.minute = MINUTE_W'((sod / 64'd60) % 64'd60);
		r.second = SECOND_W'(sod % 64'd60);
		return r;
	endfunction

	function automatic logic [JD_W-1:0] random_stamp();
		longint unsigned z, sod;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				return JD_W'({$urandom(), $urandom()});
			end
			5, 6: begin
				z   = 64'd2299161 - 64'd400 + 64'($urandom_range(0, 800));
				sod = 64'($urandom_range(0, 86399));
			end
			7: begin
				z   = 64'($urandom_range(1, 12725828));
				sod = 64'(DAY_BOUNDARY_SODS[$urandom_range(0, 5)]);
			end
			default: begin
				z   = 64'($urandom_range(2400000, 2500000));
				sod = 64'($urandom_range(0, 86399));
			end
		endcase
		return JD_W'(z * 64'd86400 + sod - 64'd43200);
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Offers one request and records its expected date once it is taken.
	task automatic offer_stamp(input logic [JD_W-1:0] jd, input logic typed,
			input cal_t cal);
		stamp.valid      <= 1'b1;
		stamp.jd_seconds <= jd;
		@(posedge clk);
		while (!stamp.ready) @(posedge clk);
		pending_dates.push_back(typed ? cal : jd_to_calendar(jd));
	endtask

	task automatic pause_stamps(input int cycles);
		if (cycles > 0) begin
			stamp.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain_dates();
		stamp.valid <= 1'b0;
		do @(posedge clk); while (pending_dates.size() != 0);
	endtask

	initial begin : stimulus
		int sent;
		int burst;
		bit pressed;
		bit drained;
		sent    = 0;
		pressed = 1'b0;
		drained = 1'b0;
		arst_n           <= 1'b0;
		stamp.valid      <= 1'b0;
		stamp.jd_seconds <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (STAMP_ROWS[i]) begin
			offer_stamp(STAMP_ROWS[i].jd, STAMP_ROWS[i].typed, STAMP_ROWS[i].cal);
			pause_stamps($urandom_range(0, 2));
		end
		drain_dates();

		while (sent < RANDOM_ITEMS) begin
			// The receiver holds off while requests keep coming, so the pipeline fills.
			if (!pressed && sent >= 400) begin
				pressed = 1'b1;
				hold_req <= 1'b1;
				repeat (100) begin
					offer_stamp(random_stamp(), 1'b0, '0);
					sent++;
				end
			end
			if (!drained && sent >= 900) begin
				drained = 1'b1;
				drain_dates();
			end
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				offer_stamp(random_stamp(), 1'b0, '0);
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause_stamps($urandom_range(1, 8));
		end
		drain_dates();
		repeat (NUM_STAGES + 26) @(posedge clk);

		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin : receiver
		sink_mode_t mode;
		int         len;
		int         phase;
		phase = 0;
		date.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				date.ready <= 1'b0;
				hold_req   <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = sink_mode_t'($urandom_range(0, 2));
				len  = $urandom_range(1, 40);
				repeat (len) begin
					case (mode)
						SINK_OPEN:    date.ready <= 1'b1;
						SINK_RANDOM:  date.ready <= ($urandom_range(0, 3) != 0);
						SINK_PATTERN: date.ready <= ((phase % 3) != 0);
						default:      date.ready <= 1'b1;
					endcase
					phase++;
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : date_check
		cal_t want;
		if (arst_n && date.valid && date.ready) begin
			if (pending_dates.size() == 0) begin
				mismatches++;
				$display("%0t ns: date %0d-%0d-%0d %0d:%0d:%0d arrived with none expected",
					$time, date.year, date.month, date.day, date.hour, date.minute,
					date.second);
			end else begin
				want = pending_dates.pop_front();
				check_field("year", want.year, date.year);
				check_field("month", want.month, date.month);
				check_field("day", want.day, date.day);
				check_field("hour", want.hour, date.hour);
				check_field("minute", want.minute, date.minute);
				check_field("second", want.second, date.second);
			end
		end
	end

endmodule

/* files.f */
rtl/jdc_pkg.sv
rtl/jdc_if.sv
rtl/julian_date_to_calendar.sv
dv/tb.sv
